### hdl/smpq_pkg.sv
// Shared constants, types and codes of the stable max-first priority queue.
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int PRIO_W = 32;
  localparam int OCC_W  = 7;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [DATA_W-1:0] DATA_NONE  = '1;
  localparam logic [DATA_W-1:0] DATA_ZERO  = '0;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

### hdl/smpq_if.sv
// Valid/ready channel interfaces for the queue's request and result beats.
`timescale 1ns / 1ps

interface smpq_in_if;
  import smpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [DATA_W-1:0] data_in;
  logic signed [PRIO_W-1:0] priority_in;

  modport source (output valid, action, data_in, priority_in, input ready);
  modport sink   (input valid, action, data_in, priority_in, output ready);
endinterface

interface smpq_out_if;
  import smpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [1:0]               status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, data_out, status, occupancy, input ready);
  modport sink   (input valid, data_out, status, occupancy, output ready);
endinterface

### hdl/stable_max_priority_queue_core.sv
// Top level: a row of sorted cells with an occupancy counter and a result register.
//
//   channel   direction  payload                          beat taken when
//   in_ch     sink       action, data_in, priority_in     valid && ready
//   out_ch    source     data_out, status, occupancy      valid && ready
//
// One request beat is taken per cycle while the request side is ready; its
// result appears in the result register on the next cycle. The cells stay
// sorted by priority, so an insert is one compare per cell and a removal is a
// shift of the row toward the head. Reset (rst_n low at a clock edge) empties
// the queue and drops any pending result beat. A stalled result holds the
// request side unless it is taken in the same cycle.
`timescale 1ns / 1ps

module stable_max_priority_queue_core (
  input  logic       clk,
  input  logic       rst_n,
  smpq_in_if.sink    in_ch,
  smpq_out_if.source out_ch
);
  import smpq_pkg::*;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic [1:0]        out_status_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic              accept;
  logic              full;
  logic              empty;
  cell_ctrl_t        ctrl;
  entry_t            new_e;
  entry_t            cells_e [DEPTH];
  logic              cells_ge [DEPTH];
  logic [DATA_W-1:0] res_data;
  logic [1:0]        res_status;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(DEPTH));
  assign empty       = (count_r == '0);

  assign ctrl.enq   = accept && (in_ch.action == ACT_ENQ) && !full;
  assign ctrl.deq   = accept && (in_ch.action == ACT_DEQ) && !empty;
  assign new_e.data = in_ch.data_in;
  assign new_e.prio = in_ch.priority_in;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_ge;

    // The head cell sees the new pair as its left neighbor.
    if (i == 0) begin : g_head
      assign prev_e  = new_e;
      assign prev_ge = 1'b0;
    end else begin : g_body
      assign prev_e  = cells_e[i-1];
      assign prev_ge = cells_ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_e = cells_e[i];
    end else begin : g_mid
      assign next_e = cells_e[i+1];
    end

    smpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .slot_valid (CNT_W'(i) < count_r),
      .new_e      (new_e),
      .prev_e     (prev_e),
      .prev_ge    (prev_ge),
      .next_e     (next_e),
      .cur_e      (cells_e[i]),
      .ge         (cells_ge[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    res_data   = DATA_ZERO;
    res_status = ST_OK;
    if (in_ch.action == ACT_ENQ) begin
      if (full) begin
        res_status = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        res_status = ST_EMPTY;
        res_data   = DATA_NONE;
      end else begin
        res_data  = cells_e[0].data;
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= res_data;
      out_status_r <= res_status;
      out_occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.data_out  = out_data_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.occupancy = out_occ_r;

endmodule

### hdl/smpq_cell.sv
// One slot of the sorted queue: keeps, takes a new pair, or shifts with a neighbor.
`timescale 1ns / 1ps

module smpq_cell (
  input  logic                 clk,
  input  smpq_pkg::cell_ctrl_t ctrl,
  input  logic                 slot_valid,
  input  smpq_pkg::entry_t     new_e,
  input  smpq_pkg::entry_t     prev_e,
  input  logic                 prev_ge,
  input  smpq_pkg::entry_t     next_e,
  output smpq_pkg::entry_t     cur_e,
  output logic                 ge
);
  import smpq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // A stored entry at or above the new priority stays ahead of it, which keeps
  // equal priorities in arrival order.
  assign ge    = slot_valid && ($signed(entry_r.prio) >= $signed(new_e.prio));
  assign cur_e = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.enq) begin
      if (!ge) begin
        entry_nxt = prev_ge ? new_e : prev_e;
      end
    end else if (ctrl.deq) begin
      entry_nxt = next_e;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### sim/smpq_reply_checker.sv
// Watches both queue channels, tracks the queue contents and checks every result beat.
`timescale 1ns / 1ps

module smpq_reply_checker
  import smpq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  smpq_in_if   req,
  smpq_out_if  rsp,
  output int   mismatches,
  output int   replies_waiting,
  output int   results_seen,
  output int   full_drops,
  output int   empty_pops
);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [1:0]        status;
    logic [OCC_W-1:0]  occ;
  } queue_reply_t;

  // Entries are kept in arrival order, so the oldest of equal priorities is found first.
  logic signed [DATA_W-1:0] held_data [DEPTH];
  logic signed [PRIO_W-1:0] held_prio [DEPTH];
  int                       held_count;

  queue_reply_t replies_due [$];

  initial begin
    mismatches      = 0;
    replies_waiting = 0;
    results_seen    = 0;
    full_drops      = 0;
    empty_pops      = 0;
    held_count      = 0;
  end

  function automatic queue_reply_t serve_request(input logic act,
                                                 input logic signed [DATA_W-1:0] d,
                                                 input logic signed [PRIO_W-1:0] p);
    queue_reply_t r;
    int           best;
    r.data   = DATA_ZERO;
    r.status = ST_OK;
    if (act == ACT_ENQ) begin
      if (held_count >= DEPTH) begin
        r.status = ST_FULL;
        full_drops++;
      end else begin
        held_data[held_count] = d;
        held_prio[held_count] = p;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
      r.data   = DATA_NONE;
      empty_pops++;
    end else begin
      best = 0;
      for (int i = 1; i < held_count; i++) begin
        if (held_prio[i] > held_prio[best]) begin
          best = i;
        end
      end
      r.data = held_data[best];
      for (int i = best; i + 1 < held_count; i++) begin
        held_data[i] = held_data[i + 1];
        held_prio[i] = held_prio[i + 1];
      end
      held_count--;
    end
    r.occ = OCC_W'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    queue_reply_t want;
    if (rst_n) begin
      // The result leaving now belongs to an earlier request, so check it first.
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding: data %h status %0d",
                                    rsp.data_out, rsp.status));
        end else begin
          want = replies_due.pop_front();
          if (rsp.data_out !== want.data) begin
            report_mismatch($sformatf("data_out %h, want %h", rsp.data_out, want.data));
          end
          if (rsp.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
          end
          if (rsp.occupancy !== want.occ) begin
            report_mismatch($sformatf("occupancy %0d, want %0d", rsp.occupancy, want.occ));
          end
        end
      end
      if (req.valid && req.ready) begin
        replies_due.push_back(serve_request(req.action, req.data_in, req.priority_in));
      end
    end
    replies_waiting = replies_due.size();
  end

endmodule

### sim/tb.sv
// Top of the queue testbench: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module tb;
  import smpq_pkg::*;

  localparam int ITEMS      = 1150;
  localparam int IDLE_LIMIT = 2000;

  typedef enum logic [1:0] {RX_OPEN, RX_THIRDS, RX_COIN, RX_CHOKE} rx_mode_t;
  typedef enum logic [1:0] {RUN_FILL, RUN_DRAIN, RUN_MIX} run_kind_t;

  logic clk;
  logic rst_n;

  smpq_in_if  req ();
  smpq_out_if rsp ();

  int mismatches;
  int replies_waiting;
  int results_seen;
  int full_drops;
  int empty_pops;

  int       sent;
  int       burst_left;
  int       idle_cycles;
  rx_mode_t rx_mode;
  int       rx_mode_left;
  logic [7:0] rx_tick;

  stable_max_priority_queue_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req),
    .out_ch (rsp)
  );

  smpq_reply_checker reply_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .rsp             (rsp),
    .mismatches      (mismatches),
    .replies_waiting (replies_waiting),
    .results_seen    (results_seen),
    .full_drops      (full_drops),
    .empty_pops      (empty_pops)
  );

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    req.valid       = 1'b0;
    req.action      = ACT_ENQ;
    req.data_in     = '0;
    req.priority_in = '0;
    rsp.ready       = 1'b0;
    sent            = 0;
    burst_left      = 0;
    idle_cycles     = 0;
    rx_mode         = RX_OPEN;
    rx_mode_left    = 0;
    rx_tick         = '0;
  end

  always #2 clk = ~clk;

  // The result side walks through stall patterns of its own, each for a random stretch.
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(8, 40);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   rsp.ready <= 1'b1;
      RX_THIRDS: rsp.ready <= (rx_tick % 3 != 0);
      RX_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
      default:   rsp.ready <= (rx_tick[3:0] >= 4'd10);
    endcase
    rx_tick <= rx_tick + 8'd1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: %0d cycles without a beat on either channel", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return DATA_NONE;
      3:       return DATA_ZERO;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Small priorities are favored so that ties are common.
  function automatic logic [PRIO_W-1:0] pick_priority();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return PRIO_W'(int'($urandom_range(0, 4)) - 2);
      4:          return {1'b1, {(PRIO_W-1){1'b0}}};
      5:          return {1'b0, {(PRIO_W-1){1'b1}}};
      default:    return PRIO_W'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_request(input logic act, input logic [DATA_W-1:0] d,
                              input logic [PRIO_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 20);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        req.valid <= 1'b0;
        @(negedge clk);
      end
    end
    req.valid       <= 1'b1;
    req.action      <= act;
    req.data_in     <= d;
    req.priority_in <= p;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic enqueue(input logic [DATA_W-1:0] d, input logic [PRIO_W-1:0] p);
    send_request(ACT_ENQ, d, p);
  endtask

  task automatic dequeue();
    send_request(ACT_DEQ, DATA_W'($urandom), PRIO_W'($urandom));
  endtask

  initial begin
    run_kind_t kind;
    int        run_len;
    int        enq_pct;
    int        run_idx;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty queue, field extremes, ties broken by arrival order.
    dequeue();
    enqueue(32'h7fff_ffff, 32'h8000_0000);
    enqueue(32'h8000_0000, 32'h7fff_ffff);
    enqueue(32'h0000_0000, 32'h0000_0000);
    enqueue(32'h0000_0001, 32'h0000_0000);
    enqueue(32'hffff_ffff, 32'h0000_0000);
    enqueue(32'h0000_007b, 32'h7fff_ffff);
    repeat (6) dequeue();
    dequeue();
    send_request(ACT_DEQ, 32'hffff_ffff, 32'hffff_ffff);
    enqueue(32'h0000_00a1, 32'hffff_ffff);
    enqueue(32'h0000_00a2, 32'h0000_0001);
    enqueue(32'h0000_00a3, 32'h8000_0001);
    repeat (4) dequeue();

    // Random runs: the first two fill past full and drain past empty.
    run_idx = 0;
    while (sent < ITEMS) begin
      if (run_idx == 0) begin
        kind = RUN_FILL;
      end else if (run_idx == 1) begin
        kind = RUN_DRAIN;
      end else begin
        case ($urandom_range(0, 5))
          0:       kind = RUN_FILL;
          1:       kind = RUN_DRAIN;
          default: kind = RUN_MIX;
        endcase
      end
      case (kind)
        RUN_FILL: begin
          run_len = $urandom_range(DEPTH + 2, DEPTH + 10);
          enq_pct = 100;
        end
        RUN_DRAIN: begin
          run_len = $urandom_range(DEPTH + 2, DEPTH + 10);
          enq_pct = 0;
        end
        default: begin
          run_len = $urandom_range(20, 60);
          enq_pct = 35 + 15 * $urandom_range(0, 2);
        end
      endcase
      repeat (run_len) begin
        if ($urandom_range(0, 99) < enq_pct) begin
          enqueue(pick_data(), pick_priority());
        end else begin
          dequeue();
        end
      end
      run_idx++;
    end
    req.valid <= 1'b0;

    while (replies_waiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Run covered %0d requests and %0d checked results in %0d runs,", sent,
             results_seen, run_idx);
    $display("with %0d drops on a full queue and %0d dequeues of an empty one; %0d mismatches.",
             full_drops, empty_pops, mismatches);
    if (mismatches == 0 && replies_waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/smpq_pkg.sv
hdl/smpq_if.sv
hdl/smpq_cell.sv
hdl/stable_max_priority_queue_core.sv
sim/smpq_reply_checker.sv
sim/tb.sv
